// ===== rtl/core/plrt_pkg.sv =====
package plrt_pkg;

	localparam int NUM_LENGTHS = 129;
	localparam int COUNT_BITS  = 16;

	// index into the per-length stores, and a width that can hold the list length
	localparam int LEN_W   = $clog2(NUM_LENGTHS);
	localparam int TOTAL_W = $clog2(NUM_LENGTHS + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_DEL  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_NEG       = 3'd1;
	localparam logic [2:0] STAT_RANGE     = 3'd2;
	localparam logic [2:0] STAT_UNDERFLOW = 3'd3;
	localparam logic [2:0] STAT_SATURATED = 3'd4;
	localparam logic [2:0] STAT_INDEX     = 3'd5;

endpackage

// ===== rtl/core/prefix_length_refcount_tracker_core.sv =====
// Sequence: capture, lookup, execute, then respond; a command that moves a count
//   between zero and nonzero runs a list rebuild scan before respond.
// A new command is taken only after the last result is accepted; the rebuild
//   scan reads one nonzero flag per cycle and writes an entry for each set flag.
// Reset (arst_n low, asynchronous): all counts read as zero, list empty,
//   generation zero, block idle and ready. No clearing pass is needed.
module prefix_length_refcount_tracker_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic signed [8:0] prefix_len,
	input  logic [7:0]        list_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [31:0]       generation,
	output logic [7:0]        active_count,
	output logic [7:0]        list_entry
);
	import plrt_pkg::*;

	// One-hot sequencer: capture, read the stores, execute, optional scan, respond.
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_LOOKUP = 5'b00010,
		S_EXEC   = 5'b00100,
		S_SCAN   = 5'b01000,
		S_RESP   = 5'b10000
	} state_t;

	state_t state_q;

	// Captured command fields
	logic [1:0]        cmd_q;
	logic [8:0]        plen_q;
	logic [7:0]        idx_q;

	// Reference count memory; nz_q doubles as the per-entry valid bit, so an
	// entry whose flag is clear reads as zero whatever the memory holds.
	logic [COUNT_BITS-1:0] cnt_mem [NUM_LENGTHS];
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [NUM_LENGTHS-1:0] nz_q;

	// Descending list of active lengths; only positions below total_q are read.
	logic [LEN_W-1:0] al_mem [NUM_LENGTHS];
	logic [LEN_W-1:0] al_rd_q;

	logic [TOTAL_W-1:0] total_q;
	logic [31:0]        gen_q;

	// Rebuild scan: length pointer walks down, fill pointer walks up.
	logic [LEN_W-1:0]   scan_q;
	logic [TOTAL_W-1:0] fill_q;
	logic [TOTAL_W-1:0] fill_nxt;

	logic [2:0] status_q;
	logic [7:0] entry_q;

	// Execute-stage decode
	logic                  plen_neg;
	logic                  plen_big;
	logic                  plen_ok;
	logic [LEN_W-1:0]      addr;
	logic                  read_hit;
	logic [COUNT_BITS-1:0] count_cur;
	logic [COUNT_BITS-1:0] count_nxt;
	logic [2:0]            exec_status;
	logic                  exec_upd;
	logic                  exec_rebuild;

	assign plen_neg = plen_q[8];
	assign plen_big = {1'b0, plen_q[7:0]} >= 9'(NUM_LENGTHS);
	assign plen_ok  = !plen_neg && !plen_big;
	assign addr     = plen_q[LEN_W-1:0];
	assign read_hit = idx_q < 8'(total_q);

	assign count_cur = nz_q[addr] ? cnt_rd_q : '0;
	assign fill_nxt  = fill_q + TOTAL_W'(nz_q[scan_q]);

	// Increment or decrement of the selected count, with the status checks around it.
	always_comb begin
		exec_status  = STAT_OK;
		exec_upd     = 1'b0;
		exec_rebuild = 1'b0;
		count_nxt    = count_cur;
		case (cmd_q)
			CMD_ADD: begin
				if (plen_neg) begin
					exec_status = STAT_NEG;
				end else if (plen_big) begin
					exec_status = STAT_RANGE;
				end else if (count_cur == COUNT_MAX) begin
					exec_status = STAT_SATURATED;
				end else begin
					exec_upd     = 1'b1;
					count_nxt    = count_cur + 1'b1;
					exec_rebuild = (count_cur == '0);
				end
			end
			CMD_DEL: begin
				if (plen_neg) begin
					exec_status = STAT_NEG;
				end else if (plen_big) begin
					exec_status = STAT_RANGE;
				end else if (count_cur == '0) begin
					exec_status = STAT_UNDERFLOW;
				end else begin
					exec_upd     = 1'b1;
					count_nxt    = count_cur - 1'b1;
					exec_rebuild = (count_cur == COUNT_BITS'(1));
				end
			end
			CMD_READ: begin
				if (!read_hit) begin
					exec_status = STAT_INDEX;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nz_q    <= '0;
			total_q <= '0;
			gen_q   <= '0;
			scan_q  <= '0;
			fill_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_upd) begin
						gen_q      <= gen_q + 32'd1;
						nz_q[addr] <= (count_nxt != '0);
					end
					if (exec_rebuild) begin
						scan_q  <= LEN_W'(NUM_LENGTHS - 1);
						fill_q  <= '0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SCAN: begin
					fill_q <= fill_nxt;
					scan_q <= scan_q - 1'b1;
					if (scan_q == '0) begin
						total_q <= fill_nxt;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: capture on the input transfer, result at execute
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= cmd;
			plen_q <= prefix_len;
			idx_q  <= list_index;
		end
		if (state_q == S_EXEC) begin
			status_q <= exec_status;
			entry_q  <= (cmd_q == CMD_READ && read_hit) ? 8'(al_rd_q) : 8'd0;
		end
	end

	// Count memory: read in lookup, write back in execute
	always_ff @(posedge clk) begin
		if (state_q == S_LOOKUP && plen_ok) begin
			cnt_rd_q <= cnt_mem[addr];
		end
		if (state_q == S_EXEC && exec_upd) begin
			cnt_mem[addr] <= count_nxt;
		end
	end

	// List memory: read in lookup, fill during the scan
	always_ff @(posedge clk) begin
		if (state_q == S_LOOKUP && cmd_q == CMD_READ && read_hit) begin
			al_rd_q <= al_mem[idx_q[LEN_W-1:0]];
		end
		if (state_q == S_SCAN && nz_q[scan_q]) begin
			al_mem[fill_q[LEN_W-1:0]] <= scan_q;
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = (state_q == S_RESP);
	assign status       = status_q;
	assign generation   = gen_q;
	assign active_count = 8'(total_q);
	assign list_entry   = entry_q;

	// Never take a new command while a result is on offer.
	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input accepted while a result is pending");

	// The list can never hold more lengths than exist.
	assert property (@(posedge clk) disable iff (!arst_n)
		active_count <= 8'(NUM_LENGTHS))
		else $error("active count beyond number of lengths");

	// Generation moves by exactly one per successful update.
	assert property (@(posedge clk) disable iff (!arst_n)
		(generation != $past(generation)) |-> (generation == $past(generation) + 32'd1))
		else $error("generation jumped");

	// A nonzero list entry is only returned by a successful read.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && list_entry != 8'd0) |-> (status == STAT_OK))
		else $error("list entry returned with error status");

endmodule

// ===== tb/plrt_route_checker.sv =====
module plrt_route_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic signed [8:0] prefix_len,
	input  logic [7:0]        list_index,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [2:0]        status,
	input  logic [31:0]       generation,
	input  logic [7:0]        active_count,
	input  logic [7:0]        list_entry,
	output int                mismatches,
	output int                pending
);
	import plrt_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] generation;
		logic [7:0]  active_count;
		logic [7:0]  list_entry;
	} route_result_t;

	logic [COUNT_BITS-1:0] len_refs [NUM_LENGTHS];
	logic [7:0]            desc_lengths [NUM_LENGTHS];
	int                    live_total;
	logic [31:0]           gen_ctr;
	route_result_t         owed_results [$];

	// Collect the lengths with a nonzero count, longest first.
	function automatic void relist_lengths();
		int n;
		n = 0;
		for (int l = NUM_LENGTHS - 1; l >= 0; l--) begin
			if (len_refs[l] != '0) begin
				desc_lengths[n] = 8'(l);
				n++;
			end
		end
		live_total = n;
	endfunction

	function automatic route_result_t apply_route_cmd(input logic [1:0] op,
			input logic signed [8:0] plen, input logic [7:0] idx);
		route_result_t r;
		int slot;
		r.status     = STAT_OK;
		r.list_entry = '0;
		case (op) inside
			CMD_ADD, CMD_DEL: begin
				slot = int'(plen[7:0]);
				if (plen[8]) begin
					r.status = STAT_NEG;
				end else if (slot >= NUM_LENGTHS) begin
					r.status = STAT_RANGE;
				end else if (op == CMD_ADD) begin
					if (len_refs[slot] == COUNT_MAX) begin
						r.status = STAT_SATURATED;
					end else begin
						gen_ctr++;
						len_refs[slot]++;
						if (len_refs[slot] == 1) relist_lengths();
					end
				end else begin
					if (len_refs[slot] == '0) begin
						r.status = STAT_UNDERFLOW;
					end else begin
						gen_ctr++;
						len_refs[slot]--;
						if (len_refs[slot] == '0) relist_lengths();
					end
				end
			end
			CMD_READ: begin
				if (int'(idx) >= live_total) r.status = STAT_INDEX;
				else r.list_entry = desc_lengths[idx];
			end
			default: ;
		endcase
		r.generation   = gen_ctr;
		r.active_count = 8'(live_total);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		route_result_t want;
		if (!arst_n) begin
			foreach (len_refs[i]) len_refs[i] = '0;
			foreach (desc_lengths[i]) desc_lengths[i] = '0;
			live_total = 0;
			gen_ctr    = '0;
			owed_results.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			// Check the result before queuing a new expectation from this edge.
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					$error("result transfer with no pending expectation");
					mismatches <= mismatches + 1;
				end else begin
					want = owed_results.pop_front();
					if (status !== want.status ||
					    generation !== want.generation ||
					    active_count !== want.active_count ||
					    list_entry !== want.list_entry)
						mismatches <= mismatches + 1;
					if (status !== want.status)
						$error("status mismatch: expected %0d, actual %0d",
							want.status, status);
					if (generation !== want.generation)
						$error("generation mismatch: expected %0d, actual %0d",
							want.generation, generation);
					if (active_count !== want.active_count)
						$error("active_count mismatch: expected %0d, actual %0d",
							want.active_count, active_count);
					if (list_entry !== want.list_entry)
						$error("list_entry mismatch: expected %0d, actual %0d",
							want.list_entry, list_entry);
				end
			end
			if (in_valid && in_ready)
				owed_results.push_back(apply_route_cmd(cmd, prefix_len, list_index));
			pending <= owed_results.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
module tb;
	import plrt_pkg::*;

	// cmd 3 has no function; the block must answer it without touching state
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 1300;
	localparam int LONG_HOLD    = 500;
	// worst case for one item includes a full rebuild scan; give the tail some slack
	localparam int DRAIN_CYCLES = 3 + NUM_LENGTHS + 20;
	localparam int CYCLE_LIMIT  = 4_000_000;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic [1:0]        cmd        = CMD_ADD;
	logic signed [8:0] prefix_len = '0;
	logic [7:0]        list_index = '0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic [2:0]        status;
	logic [31:0]       generation;
	logic [7:0]        active_count;
	logic [7:0]        list_entry;

	int mismatches;
	int pending;

	// idle knobs: the gaps and hold_req are set by the stimulus process, hold_done by the receiver
	int send_gap_max = 5;
	int recv_gap_max = 5;
	bit hold_req     = 1'b0;
	bit hold_done    = 1'b0;
	int cycle_count;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	prefix_length_refcount_tracker_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.prefix_len   (prefix_len),
		.list_index   (list_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.generation   (generation),
		.active_count (active_count),
		.list_entry   (list_entry)
	);

	plrt_route_checker route_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.prefix_len   (prefix_len),
		.list_index   (list_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.generation   (generation),
		.active_count (active_count),
		.list_entry   (list_entry),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	// Offer one command and hold it until the transfer. A random gap of idle
	// cycles goes in front; with no gap, valid stays high from the last item.
	task automatic send_cmd(input logic [1:0] op, input logic [8:0] plen,
			input logic [7:0] idx);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		prefix_len <= plen;
		list_index <= idx;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// Mostly lengths from a small pool, so counts climb above one and fall
	// back to zero often; the rest spread over the whole legal range.
	function automatic logic [8:0] pick_length();
		logic [7:0] pool [12] = '{0, 8, 16, 24, 32, 48, 64, 96, 112, 120, 127, 128};
		if ($urandom_range(0, 9) < 7) return {1'b0, pool[$urandom_range(0, 11)]};
		return 9'($urandom_range(0, NUM_LENGTHS - 1));
	endfunction

	function automatic logic [7:0] pick_index();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return 8'($urandom_range(0, 12));
		if (r < 95) return 8'($urandom_range(0, NUM_LENGTHS + 6));
		return 8'($urandom);
	endfunction

	// Commands the block refuses or ignores: negative lengths, lengths past
	// the table, and the unused command code.
	task automatic send_noise();
		logic [1:0] op;
		op = $urandom_range(0, 1) ? CMD_DEL : CMD_ADD;
		case ($urandom_range(0, 2))
			0: send_cmd(op, {1'b1, 8'($urandom)}, 8'($urandom));
			1: send_cmd(op, 9'($urandom_range(NUM_LENGTHS, 255)), 8'($urandom));
			default: send_cmd(CMD_UNUSED, 9'($urandom), 8'($urandom));
		endcase
	endtask

	// Receiver: draw a stall before each result, and once take a long
	// hold-off so the result path backs up into the input.
	initial begin
		int w;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				w = LONG_HOLD;
				hold_done = 1'b1;
			end else begin
				w = $urandom_range(0, recv_gap_max);
			end
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Watchdog: stop a hung run.
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("status: fail");
		$finish;
	end

	initial begin
		int useful;
		int r;
		bit swept;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, refused lengths, underflow, list order.
		send_cmd(CMD_READ, 9'h000, 8'd0);
		send_cmd(CMD_ADD, 9'h1FF, 8'd0);
		send_cmd(CMD_DEL, 9'h100, 8'hFF);
		send_cmd(CMD_ADD, 9'd129, 8'd0);
		send_cmd(CMD_DEL, 9'd255, 8'd0);
		send_cmd(CMD_DEL, 9'd5, 8'd0);
		send_cmd(CMD_ADD, 9'd0, 8'd0);
		send_cmd(CMD_ADD, 9'd128, 8'd0);
		send_cmd(CMD_ADD, 9'd64, 8'd0);
		send_cmd(CMD_ADD, 9'd64, 8'd0);
		send_cmd(CMD_READ, 9'h000, 8'd0);
		send_cmd(CMD_READ, 9'h1FF, 8'd1);
		send_cmd(CMD_READ, 9'h000, 8'd2);
		send_cmd(CMD_READ, 9'h000, 8'd3);
		send_cmd(CMD_READ, 9'h000, 8'd128);
		send_cmd(CMD_READ, 9'h000, 8'd255);
		send_cmd(CMD_UNUSED, 9'h1FF, 8'hFF);
		send_cmd(CMD_UNUSED, 9'h000, 8'h00);
		send_cmd(CMD_DEL, 9'd64, 8'd0);
		send_cmd(CMD_DEL, 9'd64, 8'd0);
		send_cmd(CMD_DEL, 9'd64, 8'd0);
		send_cmd(CMD_DEL, 9'd0, 8'd0);

		// Back to back on one length: raise and lower its count with no
		// idle cycles on either side.
		send_gap_max = 0;
		recv_gap_max = 0;
		send_cmd(CMD_ADD, 9'd1, 8'd0);
		send_cmd(CMD_DEL, 9'd1, 8'd0);
		send_cmd(CMD_ADD, 9'd1, 8'd0);
		send_cmd(CMD_ADD, 9'd1, 8'd0);

		// Random: adds, deletes and reads with some noise mixed in. Idle
		// settings change every hundred items, sometimes to none at all.
		useful = 0;
		swept  = 1'b0;
		while (useful < RANDOM_ITEMS) begin
			if (useful % 100 == 0) begin
				send_gap_max = $urandom_range(0, 1) ? 5 : 0;
				recv_gap_max = $urandom_range(0, 1) ? 5 : 0;
			end
			if (useful == 50) hold_req = 1'b1;

			// Once: fill every length, read the whole list, then empty it.
			if (useful >= 300 && !swept) begin
				swept = 1'b1;
				for (int l = 0; l < NUM_LENGTHS; l++)
					send_cmd(CMD_ADD, 9'(l), 8'($urandom));
				for (int i = 0; i < NUM_LENGTHS + 3; i++)
					send_cmd(CMD_READ, 9'($urandom), 8'(i));
				for (int l = NUM_LENGTHS - 1; l >= 0; l--)
					send_cmd(CMD_DEL, 9'(l), 8'($urandom));
				useful += 3 * NUM_LENGTHS + 3;
			end

			r = $urandom_range(0, 99);
			if (r < 42) begin
				send_cmd(CMD_ADD, pick_length(), 8'($urandom));
				useful++;
			end else if (r < 77) begin
				send_cmd(CMD_DEL, pick_length(), 8'($urandom));
				useful++;
			end else if (r < 95) begin
				send_cmd(CMD_READ, 9'($urandom), pick_index());
				useful++;
			end else begin
				send_noise();
			end
		end
		in_valid <= 1'b0;

		// Drain: wait for every owed result, then linger for stray ones.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
